@@ sv/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes of the periodic timer table
// Operation codes, result status codes and the layout of one table entry.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_FIRE  = 16;

  localparam logic [1:0] FN_ADD_REP = 2'd0;
  localparam logic [1:0] FN_ADD_ONE = 2'd1;
  localparam logic [1:0] FN_REMOVE  = 2'd2;
  localparam logic [1:0] FN_TICK    = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FIRED    = 3'd5;
  localparam logic [2:0] ST_NONE     = 3'd6;

  typedef struct packed {
    logic [7:0]  key;
    logic        oneshot;
    logic [15:0] period;
    logic [31:0] due;
  } entry_t;

endpackage

@@ sv/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// ptt_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/periodic_task_timer_table_core.sv @@
// ----------------------------------------------------------------------------
// periodic_task_timer_table_core: table of periodic and one-shot timers
// Holds SLOTS timer entries in a RAM; each request adds, removes or ticks.
//
//   channel  direction  ports                                         beats
//   in_      request    func, task_key, period, now_time              1
//   out_     response   status, due_time, fired_key, fired_oneshot,   1..16
//                       last
//
// Each request runs from acceptance through the scan (one RAM read per cycle
// while not stalled, each slot evaluated in the cycle after its read, then a
// last scan step to see the end), S_DONE to write back and respond, and
// S_IDLE to accept the next one. Reset clears every valid bit; RAM contents
// are don't-care until written. A stalled output holds the scan when a tick
// fires another entry behind a full output register, and holds the final
// response until the output register frees.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_core
  import ptt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_task_key,
  input  logic [15:0] in_period,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_due_time,
  output logic [7:0]  out_fired_key,
  output logic        out_fired_oneshot,
  output logic        out_last
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int FCW = $clog2(MAX_FIRE + 1);
  localparam int EW  = $bits(entry_t);
  localparam logic [CW-1:0]  SLOT_END = CW'(SLOTS);
  localparam logic [FCW-1:0] FIRE_CAP = FCW'(MAX_FIRE);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   rd_cnt_r, rd_cnt_nxt;     // next slot to read
  logic            ev_vld_r, ev_vld_nxt;     // a slot is under evaluation
  logic [IW-1:0]   ev_idx_r, ev_idx_nxt;
  logic            hit_r, hit_nxt;           // first valid key match seen
  logic [IW-1:0]   hit_idx_r, hit_idx_nxt;
  logic            free_r, free_nxt;         // first free slot seen
  logic [IW-1:0]   free_idx_r, free_idx_nxt;
  logic [FCW-1:0]  fire_cnt_r, fire_cnt_nxt;
  logic            p_vld_r, p_vld_nxt;       // held fired result
  logic            out_valid_r, out_valid_nxt;
  logic [SLOTS-1:0] valid_r;

  // Request and payload registers
  logic [1:0]  func_r, func_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [15:0] per_r, per_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] p_due_r, p_due_nxt;
  logic [7:0]  p_key_r, p_key_nxt;
  logic        p_os_r, p_os_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_due_r, out_due_nxt;
  logic [7:0]  out_key_r, out_key_nxt;
  logic        out_os_r, out_os_nxt;
  logic        out_last_r, out_last_nxt;

  // RAM interface
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata, ev_q;
  logic [EW-1:0]   mem_rdata;

  // Valid bit updates
  logic            vset, vclr;
  logic [IW-1:0]   vset_idx, vclr_idx;

  // Evaluation stage
  logic        o_free, ev_slot_vld, key_hit, fire, stall, rd_more;
  logic [31:0] ev_new_due, add_due;

  ptt_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(rd_cnt_r[IW-1:0]),
    .rdata(mem_rdata)
  );

  assign ev_q        = entry_t'(mem_rdata);
  assign o_free      = !out_valid_r || out_ready;
  assign ev_slot_vld = valid_r[ev_idx_r];
  assign key_hit     = ev_vld_r && ev_slot_vld && (ev_q.key == key_r);
  assign ev_new_due  = now_r + {16'd0, ev_q.period};
  assign add_due     = now_r + {16'd0, per_r};
  assign rd_more     = (rd_cnt_r != SLOT_END);

  // A tick fires a valid entry that is due, up to the per-tick cap
  assign fire = (state_r == S_SCAN) && ev_vld_r && (func_r == FN_TICK) &&
                ev_slot_vld && (ev_q.due <= now_r) && (fire_cnt_r < FIRE_CAP);

  // Hold the scan when a new fire needs the held result moved but the output register is not free
  assign stall  = fire && p_vld_r && !o_free;
  assign mem_re = (state_r == S_SCAN) && !stall && rd_more;

  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    ev_vld_nxt     = ev_vld_r;
    ev_idx_nxt     = ev_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    fire_cnt_nxt   = fire_cnt_r;
    p_vld_nxt      = p_vld_r;
    p_due_nxt      = p_due_r;
    p_key_nxt      = p_key_r;
    p_os_nxt       = p_os_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    per_nxt        = per_r;
    now_nxt        = now_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_due_nxt    = out_due_r;
    out_key_nxt    = out_key_r;
    out_os_nxt     = out_os_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = ev_idx_r;
    mem_wdata      = ev_q;
    vset           = 1'b0;
    vset_idx       = free_idx_r;
    vclr           = 1'b0;
    vclr_idx       = ev_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt     = in_func;
          key_nxt      = in_task_key;
          per_nxt      = in_period;
          now_nxt      = in_now_time;
          rd_cnt_nxt   = '0;
          ev_vld_nxt   = 1'b0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          fire_cnt_nxt = '0;
          p_vld_nxt    = 1'b0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (!stall) begin
          // Advance the read pointer; the slot read now is evaluated next
          ev_vld_nxt = rd_more;
          ev_idx_nxt = rd_cnt_r[IW-1:0];
          if (rd_more) begin
            rd_cnt_nxt = rd_cnt_r + 1'b1;
          end
          if (ev_vld_r) begin
            if (key_hit && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = ev_idx_r;
            end
            if (!ev_slot_vld && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = ev_idx_r;
            end
            if (fire) begin
              fire_cnt_nxt = fire_cnt_r + 1'b1;
              // Release the previous fired result, not the last one
              if (p_vld_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FIRED;
                out_due_nxt    = p_due_r;
                out_key_nxt    = p_key_r;
                out_os_nxt     = p_os_r;
                out_last_nxt   = 1'b0;
              end
              p_vld_nxt     = 1'b1;
              p_due_nxt     = ev_new_due;
              p_key_nxt     = ev_q.key;
              p_os_nxt      = ev_q.oneshot;
              // Reload the due time; drop a one-shot entry
              mem_we        = 1'b1;
              mem_wdata.due = ev_new_due;
              vclr          = ev_q.oneshot;
            end
          end
          if (!ev_vld_r && !rd_more) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (o_free) begin
          out_valid_nxt  = 1'b1;
          out_due_nxt    = '0;
          out_key_nxt    = '0;
          out_os_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          mem_waddr      = free_idx_r;
          mem_wdata.key     = key_r;
          mem_wdata.oneshot = (func_r == FN_ADD_ONE);
          mem_wdata.period  = (func_r == FN_ADD_ONE) ? 16'd0 : per_r;
          mem_wdata.due     = add_due;
          case (func_r)
            FN_ADD_REP, FN_ADD_ONE: begin
              if ((func_r == FN_ADD_REP) && hit_r) begin
                out_status_nxt = ST_DUP;
              end else if (!free_r) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_ADDED;
                out_due_nxt    = add_due;
                mem_we         = 1'b1;
                vset           = 1'b1;
              end
            end
            FN_REMOVE: begin
              vclr_idx = hit_idx_r;
              if (hit_r) begin
                out_status_nxt = ST_REMOVED;
                vclr           = 1'b1;
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            default: begin
              if (p_vld_r) begin
                out_status_nxt = ST_FIRED;
                out_due_nxt    = p_due_r;
                out_key_nxt    = p_key_r;
                out_os_nxt     = p_os_r;
              end else begin
                out_status_nxt = ST_NONE;
              end
            end
          endcase
          p_vld_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      ev_vld_r    <= 1'b0;
      ev_idx_r    <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      free_r      <= 1'b0;
      free_idx_r  <= '0;
      fire_cnt_r  <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      ev_vld_r    <= ev_vld_nxt;
      ev_idx_r    <= ev_idx_nxt;
      hit_r       <= hit_nxt;
      hit_idx_r   <= hit_idx_nxt;
      free_r      <= free_nxt;
      free_idx_r  <= free_idx_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (vclr) begin
        valid_r[vclr_idx] <= 1'b0;
      end
      if (vset) begin
        valid_r[vset_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    per_r        <= per_nxt;
    now_r        <= now_nxt;
    p_due_r      <= p_due_nxt;
    p_key_r      <= p_key_nxt;
    p_os_r       <= p_os_nxt;
    out_status_r <= out_status_nxt;
    out_due_r    <= out_due_nxt;
    out_key_r    <= out_key_nxt;
    out_os_r     <= out_os_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_due_time      = out_due_r;
  assign out_fired_key     = out_key_r;
  assign out_fired_oneshot = out_os_r;
  assign out_last          = out_last_r;

`ifndef ASSERT_OFF
  // A stall keeps the same slot under evaluation
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (ev_vld_r && $stable(ev_idx_r)))
    else $error("evaluation slot changed during a stall");

  // Only fired results may be followed by more results of the same request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_FIRED)) |-> out_last_r)
    else $error("non-fired result without last");

  // No held fired result survives the end of a request
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !p_vld_r)
    else $error("held fired result left over in idle");

  // Fire count stays within the per-tick cap
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= FIRE_CAP)
    else $error("fire count above cap");
`endif

endmodule
